### rtl/anp_pkg.sv
// Shared types and constants for the ASCII number parser.
// No dependencies; imported by anp_char_step and ascii_number_parser.
package anp_pkg;

  localparam logic [1:0] MODE_UDEC = 2'd0;
  localparam logic [1:0] MODE_SDEC = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_6     = 8'h36;
  localparam logic [7:0] CHAR_7     = 8'h37;
  localparam logic [7:0] CHAR_8     = 8'h38;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  localparam logic [31:0] UDEC_LIMIT = 32'd429496729;
  localparam logic [31:0] SDEC_LIMIT = 32'd214748364;
  localparam logic [31:0] HEX_TOP    = 32'hF000_0000;

  typedef struct packed {
    logic [31:0] acc;
    logic        err;
    logic        neg;
    logic        first;
    logic        seen;
  } anp_state_t;

  localparam anp_state_t STATE_RESET = '{acc: 32'd0, err: 1'b0, neg: 1'b0,
                                         first: 1'b1, seen: 1'b0};

endpackage

### rtl/ascii_number_parser.sv
// A terminator transfer reaches result valid through the input register, then the
//   result register. Throughput: one character per cycle unless a terminator waits,
//   set by the combinational accumulator update (x10 shift-add or x16 shift).
// A terminator waits in the input register only while the result register is full.
// Reset (synchronous, rst high): parse_mode 0, parser state cleared, both sides empty.
module ascii_number_parser
  import anp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,   // parse_mode
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] char_code
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata     // [0] ok, [32:1] value, [39:33] zero
);

  logic [1:0]  parse_mode;
  logic        in_valid;
  logic [7:0]  in_char;
  anp_state_t  state;
  anp_state_t  state_next;
  logic        res_ok;
  logic [31:0] res_value;
  logic        in_term;
  logic        out_free;
  logic        advance;
  logic        out_ok;
  logic [31:0] out_value;

  anp_char_step u_step (
    .mode       (parse_mode),
    .char_code  (in_char),
    .state      (state),
    .state_next (state_next),
    .ok         (res_ok),
    .value      (res_value)
  );

  assign in_term  = (in_char == CHAR_NUL);
  assign out_free = !m_tvalid || m_tready;
  // ordinary characters never wait on the output side
  assign advance  = in_valid && (!in_term || out_free);
  assign s_tready = !in_valid || advance;

  assign m_tdata  = {7'd0, out_value, out_ok};

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode <= MODE_UDEC;
    end else if (cfg_we) begin
      parse_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= in_term ? STATE_RESET : state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_term) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_term) begin
      out_ok    <= res_ok;
      out_value <= res_value;
    end
  end

endmodule

### rtl/anp_char_step.sv
// One-character update of the parser state, plus the result at a terminator.
// Pure combinational; depends on anp_pkg.
module anp_char_step
  import anp_pkg::*;
(
  input  logic [1:0]  mode,
  input  logic [7:0]  char_code,
  input  anp_state_t  state,
  output anp_state_t  state_next,
  output logic        ok,
  output logic [31:0] value
);

  logic        is_dec;
  logic        is_hex_letter;
  logic [7:0]  lower;
  logic [3:0]  digit;
  logic        dec_ovf;
  logic        sdec_ovf;
  logic [7:0]  sdec_lim;
  logic [31:0] acc_x10;

  always_comb begin
    lower         = char_code | CASE_BIT;
    is_dec        = (char_code >= CHAR_0) && (char_code <= CHAR_9);
    is_hex_letter = (lower >= CHAR_LA) && (lower <= CHAR_LF);
    // letters a..f have low nibble 1..6
    digit         = is_dec ? char_code[3:0] : (char_code[3:0] + 4'd9);
    dec_ovf       = (state.acc > UDEC_LIMIT) ||
                    ((state.acc == UDEC_LIMIT) && (char_code >= CHAR_6));
    sdec_lim      = state.neg ? CHAR_8 : CHAR_7;
    sdec_ovf      = (state.acc > SDEC_LIMIT) ||
                    ((state.acc == SDEC_LIMIT) && (char_code > sdec_lim));
    acc_x10       = {state.acc[28:0], 3'b000} + {state.acc[30:0], 1'b0}
                    + {28'd0, digit};
  end

  always_comb begin
    state_next       = state;
    state_next.first = 1'b0;
    if (!state.err) begin
      unique case (mode)
        MODE_UDEC: begin
          if (!is_dec || dec_ovf) begin
            state_next.err = 1'b1;
          end else begin
            state_next.acc  = acc_x10;
            state_next.seen = 1'b1;
          end
        end
        MODE_SDEC: begin
          if (state.first && (char_code == CHAR_MINUS)) begin
            state_next.neg = 1'b1;
          end else if (!is_dec || sdec_ovf) begin
            state_next.err = 1'b1;
          end else begin
            state_next.acc  = acc_x10;
            state_next.seen = 1'b1;
          end
        end
        MODE_HEX: begin
          if ((!is_dec && !is_hex_letter) || ((state.acc & HEX_TOP) != 32'd0)) begin
            state_next.err = 1'b1;
          end else begin
            state_next.acc  = {state.acc[27:0], digit};
            state_next.seen = 1'b1;
          end
        end
        default: begin
          state_next.err = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    ok = !state.err && state.seen;
    if (!ok) begin
      value = 32'd0;
    end else if (state.neg) begin
      value = 32'd0 - state.acc;
    end else begin
      value = state.acc;
    end
  end

endmodule

### bench/ascii_number_parser_tb.sv
// Self-checking bench for ascii_number_parser: character streams in all parse modes.
// Depends on anp_pkg and the ascii_number_parser RTL only; a scoreboard class predicts
// each terminator's result and checks the output stream against it.
`timescale 1ns / 1ps

module ascii_number_parser_tb;
  import anp_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [7:0] CHAR_UA     = 8'h41;
  localparam logic [7:0] CHAR_UF     = 8'h46;

  typedef struct packed {
    logic        ok;
    logic [31:0] value;
  } parse_result_t;

  class number_scoreboard;
    logic [1:0]    mode;
    logic [31:0]   acc;
    bit            bad;
    bit            minus;
    bit            fresh;
    bit            got_digit;
    parse_result_t expected_numbers[$];
    int            errors;

    function new();
      mode   = MODE_UDEC;
      errors = 0;
      clear();
    endfunction

    function void clear();
      acc       = '0;
      bad       = 1'b0;
      minus     = 1'b0;
      fresh     = 1'b1;
      got_digit = 1'b0;
    endfunction

    function int pending();
      return expected_numbers.size();
    endfunction

    // Called for every accepted input transfer.
    function void note_char(logic [7:0] ch);
      parse_result_t res;
      logic [7:0]    lim;
      logic [3:0]    nib;
      bit            first;
      if (ch == CHAR_NUL) begin
        res.ok    = !bad && got_digit;
        res.value = res.ok ? (minus ? -acc : acc) : 32'd0;
        expected_numbers.push_back(res);
        clear();
        return;
      end
      first = fresh;
      fresh = 1'b0;
      if (bad) return;
      case (mode)
        MODE_UDEC, MODE_SDEC: begin
          if (mode == MODE_SDEC && first && ch == CHAR_MINUS) begin
            minus = 1'b1;
            return;
          end
          if (ch < CHAR_0 || ch > CHAR_9) begin
            bad = 1'b1;
            return;
          end
          if (mode == MODE_UDEC) begin
            if (acc > UDEC_LIMIT || (acc == UDEC_LIMIT && ch >= CHAR_6)) begin
              bad = 1'b1;
              return;
            end
          end else begin
            // a negative number may reach one past the positive limit
            lim = minus ? CHAR_8 : CHAR_7;
            if (acc > SDEC_LIMIT || (acc == SDEC_LIMIT && ch > lim)) begin
              bad = 1'b1;
              return;
            end
          end
          acc       = acc * 32'd10 + 32'(ch - CHAR_0);
          got_digit = 1'b1;
        end
        MODE_HEX: begin
          if (ch >= CHAR_0 && ch <= CHAR_9)        nib = 4'(ch - CHAR_0);
          else if (ch >= CHAR_LA && ch <= CHAR_LF) nib = 4'(ch - CHAR_LA + 8'd10);
          else if (ch >= CHAR_UA && ch <= CHAR_UF) nib = 4'(ch - CHAR_UA + 8'd10);
          else begin
            bad = 1'b1;
            return;
          end
          if ((acc & HEX_TOP) != 32'd0) begin
            bad = 1'b1;
            return;
          end
          acc       = {acc[27:0], nib};
          got_digit = 1'b1;
        end
        default: bad = 1'b1;
      endcase
    endfunction

    function void check_result(logic [39:0] beat);
      parse_result_t want;
      if (expected_numbers.size() == 0) begin
        $display("%0t: unexpected result, expected none, got ok=%0b value=%h",
                 $time, beat[0], beat[32:1]);
        errors++;
        return;
      end
      want = expected_numbers.pop_front();
      if (beat[0] !== want.ok) begin
        $display("%0t: ok mismatch, expected %0b, got %0b", $time, want.ok, beat[0]);
        errors++;
      end
      if (beat[32:1] !== want.value) begin
        $display("%0t: value mismatch, expected %h, got %h", $time, want.value, beat[32:1]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] char_code
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [0] ok, [32:1] value, [39:33] zero

  number_scoreboard sb;
  logic [7:0]       text_q[$];
  bit               calm;
  bit               hold_req;
  int               sent;
  int               strings;

  ascii_number_parser u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin : rx_side
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      m_tready <= calm || ($urandom_range(0, 99) >= 16);
      @(posedge clk);
    end
  end

  task automatic send_char(input logic [7:0] ch);
    if (!calm && $urandom_range(0, 99) < 16) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_char(ch);
    sent++;
  endtask

  task automatic send_text(input int n);
    repeat (n) send_char(text_q.pop_front());
  endtask

  // Stop sending, let every result drain, then allow the input register to empty.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.mode = m;
  endtask

  function automatic void add_str(input string s, input bit term);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    if (term) text_q.push_back(CHAR_NUL);
  endfunction

  function automatic logic [1:0] pick_mode();
    if ($urandom_range(0, 9) == 0) return MODE_UNUSED;
    return 2'($urandom_range(0, 2));
  endfunction

  // One terminated string for the current mode, mostly numbers, some near the limits.
  function automatic void build_string();
    longint     v;
    longint     lim;
    int         base;
    int         d;
    int         kind;
    int         zeros;
    bit         neg;
    logic [7:0] ch;
    logic [7:0] digits[$];
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(0, 6)) text_q.push_back(8'($urandom_range(1, 255)));
    end else if (kind < 11) begin
      if ($urandom_range(0, 1) == 1) text_q.push_back(CHAR_MINUS);
    end else begin
      neg  = (sb.mode == MODE_SDEC) && ($urandom_range(0, 1) == 1);
      base = (sb.mode == MODE_HEX) ? 16 : 10;
      if (sb.mode == MODE_SDEC) lim = neg ? 64'd2147483648 : 64'd2147483647;
      else                      lim = 64'd4294967295;
      case ($urandom_range(0, 4))
        0:       v = longint'($urandom_range(0, 99));
        1:       v = longint'($urandom());
        2:       v = lim + (int'($urandom_range(0, 6)) - 3);
        3:       v = longint'({4'($urandom_range(0, 15)), $urandom()});
        default: v = longint'($urandom() >> $urandom_range(0, 31));
      endcase
      do begin
        d = int'(v % base);
        if (d < 10) ch = CHAR_0 + 8'(d);
        else        ch = ($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + 8'(d - 10);
        digits.push_front(ch);
        v = v / base;
      end while (v != 0);
      zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (zeros) digits.push_front(CHAR_0);
      if (neg) digits.push_front(CHAR_MINUS);
      if ($urandom_range(0, 9) == 0)
        digits[$urandom_range(0, digits.size() - 1)] = 8'($urandom_range(1, 255));
      foreach (digits[i]) text_q.push_back(digits[i]);
    end
    text_q.push_back(CHAR_NUL);
  endfunction

  initial begin : stimulus
    rst      = 1'b1;
    cfg_we   = 1'b0;
    cfg_data = MODE_UDEC;
    s_tvalid = 1'b0;
    s_tdata  = CHAR_NUL;
    calm     = 1'b0;
    hold_req = 1'b0;
    sent     = 0;
    strings  = 0;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty string, a byte with every bit set, a plain digit
    text_q.push_back(CHAR_NUL);
    text_q.push_back(8'hFF);
    text_q.push_back(CHAR_NUL);
    add_str("9", 1'b1);
    send_text(text_q.size());

    // lone minus, minus after a digit, then a sign kept across a switch to hex
    write_mode(MODE_SDEC);
    add_str("-", 1'b1);
    add_str("1-", 1'b1);
    add_str("-7", 1'b0);
    send_text(text_q.size());
    write_mode(MODE_HEX);
    add_str("f", 1'b1);
    add_str("A-", 1'b1);
    send_text(text_q.size());

    write_mode(MODE_UNUSED);
    add_str("5", 1'b1);
    send_text(text_q.size());

    write_mode(MODE_UDEC);
    while (sent < 1400) begin
      strings++;
      calm = (strings >= 60 && strings < 90);
      if (strings == 25) hold_req = 1'b1;
      // no register writes while the receiver is held off: the input must back up
      if (!(strings >= 25 && strings < 40) && $urandom_range(0, 11) == 0)
        write_mode(pick_mode());
      build_string();
      if (!(strings >= 25 && strings < 40) && $urandom_range(0, 19) == 0) begin
        send_text($urandom_range(0, text_q.size() - 1));
        write_mode(pick_mode());
      end
      send_text(text_q.size());
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
